// ===== hw/rtl/cang_pkg.sv =====
// Shared types, codes and constants of the axis neighbourhood gather block.
// No dependencies; every other file but cang_cell_mem refers to this package by scoped names.
package cang_pkg;

    localparam int GRID_DIM_DEFAULT   = 32;
    localparam int LABEL_BITS_DEFAULT = 16;
    // Upper bound on the radius along each axis.
    localparam int MAX_REACH          = 7;

    localparam int POS_BITS       = 5;
    localparam int LABEL_IN_BITS  = 16;
    localparam int OUT_LABEL_BITS = 16;
    localparam int MODE_BITS      = 2;
    localparam int REACH_BITS     = 3;
    localparam int SIZE_BITS      = 6;
    localparam int REG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 8;
    // Signed coordinate width during boundary fix-up; holds -256 .. 255.
    localparam int SCW            = 9;
    localparam int OFF_BITS       = REACH_BITS + 1;

    localparam logic [MODE_BITS-1:0] MODE_BLOCKING = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PERIODIC = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REFLECT  = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [REG_IDX_BITS-1:0] REG_BOUNDARY_MODE = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_REACH         = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_X        = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Y        = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SIZE_Z        = 3'd4;

    localparam logic [MODE_BITS-1:0]  MODE_RESET  = MODE_BLOCKING;
    localparam logic [REACH_BITS-1:0] REACH_RESET = 3'd1;
    localparam logic [SIZE_BITS-1:0]  SIZE_RESET  = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                     kind;
        logic [POS_BITS-1:0]      pos_x;
        logic [POS_BITS-1:0]      pos_y;
        logic [POS_BITS-1:0]      pos_z;
        logic [LABEL_IN_BITS-1:0] label_in;
    } item_t;

    typedef struct packed {
        logic [OUT_LABEL_BITS-1:0] neighbour_label;
        logic                      found;
        logic                      last;
    } result_t;

    typedef struct packed {
        logic [REG_IDX_BITS-1:0]  reg_index;
        logic [CFG_DATA_BITS-1:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  boundary_mode;
        logic [REACH_BITS-1:0] reach;
        logic [SIZE_BITS-1:0]  size_x;
        logic [SIZE_BITS-1:0]  size_y;
        logic [SIZE_BITS-1:0]  size_z;
    } qcfg_t;

    typedef struct packed {
        logic                start;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [POS_BITS-1:0] pos_z;
    } qstart_t;

    typedef struct packed {
        logic    valid;
        result_t item;
    } push_t;

endpackage

// ===== hw/rtl/cang_if.sv =====
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on cang_pkg for the payload types.
interface cang_item_if;
    logic          valid;
    logic          ready;
    cang_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cang_result_if;
    logic            valid;
    logic            ready;
    cang_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cang_cfg_if;
    logic            valid;
    logic            ready;
    cang_pkg::cfg_wr_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ca_axis_neighbourhood_gather.sv =====
// Axis neighbourhood gather over a 3D grid of cell labels.
// Uses cang_pkg, cang_if, cang_cell_mem and cang_query_engine.
//
// Channels: items (write or query), results (labels found, last marked) and
// cfg (register writes, always ready). Every transfer is valid && ready.
// A write item gives no result. A query walks the x, y and z lines of
// 2*reach+1 positions each, one label store read per position that lies in
// the grid in use, and keeps the block busy until its last result is handed
// over; the next item is not taken before then. A query centred outside the
// grid in use goes straight to the flush state, which gives its result;
// otherwise each found label passes the read data register and the held label
// before the output register. Results are delayed by one found label so
// that the last one can be marked; a query that finds nothing gives a single
// result with found low and last high.
// Results sit in an output register; the next item is taken while it waits.
// When results stalls and a found label must be pushed, the scan holds with
// its read data until room appears.
// After reset the label store is cleared one entry per cycle over all
// 2**(3*AW) entries (32768 at the default size); items wait for that pass,
// register writes do not.
module ca_axis_neighbourhood_gather #(
    parameter int GRID_DIM   = cang_pkg::GRID_DIM_DEFAULT,
    parameter int LABEL_BITS = cang_pkg::LABEL_BITS_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    cang_cfg_if.sink      cfg,
    cang_item_if.sink     items,
    cang_result_if.source results
);

    localparam int AW  = $clog2(GRID_DIM);
    localparam int MAW = 3 * AW;

    logic [cang_pkg::MODE_BITS-1:0]  mode_reg;
    logic [cang_pkg::REACH_BITS-1:0] reach_reg;
    logic [cang_pkg::SIZE_BITS-1:0]  size_x_reg, size_y_reg, size_z_reg;

    logic           clr_active_reg;
    logic [MAW-1:0] clr_addr_reg;

    logic              out_valid_reg;
    cang_pkg::result_t out_item_reg;

    cang_pkg::qcfg_t   qcfg;
    cang_pkg::qstart_t qstart;
    cang_pkg::push_t   push;
    logic              busy, push_ok, item_xfer, wr_hit;
    logic              mem_we, rd_en;
    logic [MAW-1:0]    mem_waddr, rd_addr;
    logic [LABEL_BITS-1:0] mem_wdata, rd_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cang_pkg::MODE_RESET;
            reach_reg  <= cang_pkg::REACH_RESET;
            size_x_reg <= cang_pkg::SIZE_RESET;
            size_y_reg <= cang_pkg::SIZE_RESET;
            size_z_reg <= cang_pkg::SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.reg_index)
                cang_pkg::REG_BOUNDARY_MODE:
                    mode_reg <= cfg.payload.wdata[cang_pkg::MODE_BITS-1:0];
                cang_pkg::REG_REACH:
                    reach_reg <= cfg.payload.wdata[cang_pkg::REACH_BITS-1:0];
                cang_pkg::REG_SIZE_X:
                    size_x_reg <= cfg.payload.wdata[cang_pkg::SIZE_BITS-1:0];
                cang_pkg::REG_SIZE_Y:
                    size_y_reg <= cfg.payload.wdata[cang_pkg::SIZE_BITS-1:0];
                cang_pkg::REG_SIZE_Z:
                    size_z_reg <= cfg.payload.wdata[cang_pkg::SIZE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clearing pass over the whole store after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + MAW'(1);
            if (clr_addr_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign items.ready = !clr_active_reg && !busy;
    assign item_xfer   = items.valid && items.ready;
    assign wr_hit      = item_xfer && (items.payload.kind == cang_pkg::KIND_WRITE)
                         && (int'(items.payload.pos_x) < GRID_DIM)
                         && (int'(items.payload.pos_y) < GRID_DIM)
                         && (int'(items.payload.pos_z) < GRID_DIM);

    assign mem_we    = clr_active_reg || wr_hit;
    assign mem_waddr = clr_active_reg ? clr_addr_reg :
                       {AW'(items.payload.pos_x), AW'(items.payload.pos_y),
                        AW'(items.payload.pos_z)};
    assign mem_wdata = clr_active_reg ? '0 : LABEL_BITS'(items.payload.label_in);

    assign qcfg.boundary_mode = mode_reg;
    assign qcfg.reach         = reach_reg;
    assign qcfg.size_x        = size_x_reg;
    assign qcfg.size_y        = size_y_reg;
    assign qcfg.size_z        = size_z_reg;

    assign qstart.start = item_xfer && (items.payload.kind == cang_pkg::KIND_QUERY);
    assign qstart.pos_x = items.payload.pos_x;
    assign qstart.pos_y = items.payload.pos_y;
    assign qstart.pos_z = items.payload.pos_z;

    cang_cell_mem #(
        .ADDR_BITS (MAW),
        .DATA_BITS (LABEL_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rd_en (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cang_query_engine #(
        .GRID_DIM   (GRID_DIM),
        .LABEL_BITS (LABEL_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .qcfg    (qcfg),
        .qstart  (qstart),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .push_ok (push_ok),
        .push    (push)
    );

    assign push_ok = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_item_reg <= push.item;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

endmodule

// ===== hw/rtl/cang_cell_mem.sv =====
// Label store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module cang_cell_mem #(
    parameter int ADDR_BITS = 15,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued; the query engine relies on it to stall.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cang_query_engine.sv =====
// Query sequencer: walks the three axis lines, applies the boundary mode,
// reads the label store and hands found labels on with the last one marked.
// Depends on cang_pkg.
module cang_query_engine #(
    parameter int GRID_DIM   = cang_pkg::GRID_DIM_DEFAULT,
    parameter int LABEL_BITS = cang_pkg::LABEL_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cang_pkg::qcfg_t                qcfg,
    input  cang_pkg::qstart_t              qstart,
    output logic                           busy,
    output logic                           rd_en,
    output logic [3*$clog2(GRID_DIM)-1:0]  rd_addr,
    input  logic [LABEL_BITS-1:0]          rd_data,
    input  logic                           push_ok,
    output cang_pkg::push_t                push
);

    localparam int AW  = $clog2(GRID_DIM);
    localparam int SCW = cang_pkg::SCW;
    localparam int OFW = cang_pkg::OFF_BITS;
    localparam logic signed [SCW-1:0] ONE = 1;

    function automatic logic signed [SCW-1:0] eff_size(input logic [cang_pkg::SIZE_BITS-1:0] s);
        logic signed [SCW-1:0] res;
        if (s == '0)
        begin
            res = ONE;
        end
        else if (int'(s) > GRID_DIM)
        begin
            res = SCW'(GRID_DIM);
        end
        else
        begin
            res = SCW'(s);
        end
        return res;
    endfunction

    cang_pkg::state_t state_reg, state_next;
    logic [cang_pkg::POS_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]                    axis_reg, axis_next;
    logic signed [OFW-1:0]         off_reg, off_next;
    logic                          b_valid_reg, b_valid_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [cang_pkg::OUT_LABEL_BITS-1:0] pend_label_reg, pend_label_next;

    logic [cang_pkg::REACH_BITS-1:0] r;
    logic signed [OFW-1:0]           r_s;
    logic signed [SCW-1:0]           sz_x, sz_y, sz_z, size;
    logic signed [SCW-1:0]           qx, qy, qz;
    logic [cang_pkg::POS_BITS-1:0]   cen;
    logic signed [SCW-1:0]           c_raw, c_fix;
    logic                            pos_ok, centre_ok, hit, b_stall;
    logic [AW-1:0]                   ax, ay, az;

    assign r    = (int'(qcfg.reach) > cang_pkg::MAX_REACH) ?
                  cang_pkg::REACH_BITS'(cang_pkg::MAX_REACH) : qcfg.reach;
    assign r_s  = $signed({1'b0, r});
    assign sz_x = eff_size(qcfg.size_x);
    assign sz_y = eff_size(qcfg.size_y);
    assign sz_z = eff_size(qcfg.size_z);
    assign qx   = SCW'(qstart.pos_x);
    assign qy   = SCW'(qstart.pos_y);
    assign qz   = SCW'(qstart.pos_z);
    assign centre_ok = (qx < sz_x) && (qy < sz_y) && (qz < sz_z);

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin cen = cx_reg; size = sz_x; end
            2'd1:    begin cen = cy_reg; size = sz_y; end
            default: begin cen = cz_reg; size = sz_z; end
        endcase
    end

    // Boundary fix-up of the coordinate on the current axis.
    always_comb
    begin
        c_raw = SCW'(cen) + SCW'(off_reg);
        c_fix = c_raw;
        if (qcfg.boundary_mode == cang_pkg::MODE_PERIODIC)
        begin
            if (c_raw < 0)
            begin
                c_fix = c_raw + size;
            end
            else if (c_raw >= size)
            begin
                c_fix = c_raw - size;
            end
        end
        else if (qcfg.boundary_mode == cang_pkg::MODE_REFLECT)
        begin
            if (c_raw < 0)
            begin
                c_fix = -c_raw - ONE;
            end
            else if (c_raw >= size)
            begin
                c_fix = (size <<< 1) - c_raw - ONE;
            end
        end
        pos_ok = (c_fix >= 0) && (c_fix < size);
    end

    always_comb
    begin
        ax = AW'(cx_reg);
        ay = AW'(cy_reg);
        az = AW'(cz_reg);
        case (axis_reg)
            2'd0:    ax = AW'(c_fix);
            2'd1:    ay = AW'(c_fix);
            default: az = AW'(c_fix);
        endcase
    end

    assign rd_addr = {ax, ay, az};
    assign busy    = (state_reg != cang_pkg::ST_IDLE);
    assign hit     = b_valid_reg && (rd_data != '0);
    // A hit must push the held label out; without room the read stage waits.
    assign b_stall = hit && pend_valid_reg && !push_ok;

    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        off_next        = off_reg;
        b_valid_next    = b_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_label_next = pend_label_reg;
        rd_en           = 1'b0;
        push            = '0;

        if (b_valid_reg && !b_stall)
        begin
            b_valid_next = 1'b0;
            if (hit)
            begin
                if (pend_valid_reg)
                begin
                    push.valid                = 1'b1;
                    push.item.neighbour_label = pend_label_reg;
                    push.item.found           = 1'b1;
                    push.item.last            = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_label_next = cang_pkg::OUT_LABEL_BITS'(rd_data);
            end
        end

        unique case (state_reg)
            cang_pkg::ST_IDLE:
            begin
                if (qstart.start)
                begin
                    axis_next  = 2'd0;
                    off_next   = -r_s;
                    state_next = centre_ok ? cang_pkg::ST_SCAN : cang_pkg::ST_FLUSH;
                end
            end
            cang_pkg::ST_SCAN:
            begin
                if (!b_stall)
                begin
                    rd_en        = pos_ok;
                    b_valid_next = pos_ok;
                    if (off_reg == r_s)
                    begin
                        off_next = -r_s;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = cang_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        off_next = off_reg + OFW'(1);
                    end
                end
            end
            cang_pkg::ST_FLUSH:
            begin
                if (!b_valid_reg && push_ok)
                begin
                    push.valid                = 1'b1;
                    push.item.neighbour_label = pend_valid_reg ? pend_label_reg : '0;
                    push.item.found           = pend_valid_reg;
                    push.item.last            = 1'b1;
                    pend_valid_next           = 1'b0;
                    state_next                = cang_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cang_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cang_pkg::ST_IDLE;
            axis_reg       <= 2'd0;
            off_reg        <= '0;
            b_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            off_reg        <= off_next;
            b_valid_reg    <= b_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_label_reg <= pend_label_next;
        if (qstart.start && (state_reg == cang_pkg::ST_IDLE))
        begin
            cx_reg <= qstart.pos_x;
            cy_reg <= qstart.pos_y;
            cz_reg <= qstart.pos_z;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench for ca_axis_neighbourhood_gather: directed table, then phased random traffic.
// Results are checked in order against a built-in model of the label grid.
// Depends on cang_pkg, the channel interfaces in cang_if and the block's RTL.
module testbench;

    localparam int GRID         = cang_pkg::GRID_DIM_DEFAULT;
    localparam int MAX_HITS     = 45;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 33;
    localparam int PLAN_LEN     = 34;

    localparam logic [cang_pkg::MODE_BITS-1:0]    MODE_SPARE = 2'd3;
    localparam logic [cang_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic              is_cfg;
        cang_pkg::cfg_wr_t cw;
        cang_pkg::item_t   it;
        logic              typed;
        cang_pkg::result_t want;
    } step_row_t;

    logic clk;
    logic rst_n;

    cang_item_if   items_if ();
    cang_result_if res_if ();
    cang_cfg_if    cfg_if ();

    ca_axis_neighbourhood_gather dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .items   (items_if),
        .results (res_if)
    );

    // model state
    logic [cang_pkg::LABEL_IN_BITS-1:0] label_mem [0:GRID*GRID*GRID-1];
    logic [cang_pkg::MODE_BITS-1:0]     cur_mode;
    logic [cang_pkg::REACH_BITS-1:0]    cur_reach;
    logic [cang_pkg::SIZE_BITS-1:0]     cur_size_x;
    logic [cang_pkg::SIZE_BITS-1:0]     cur_size_y;
    logic [cang_pkg::SIZE_BITS-1:0]     cur_size_z;

    cang_pkg::result_t due_results [$];
    int      fault_count;
    int      src_idle_pct;
    int      sink_idle_pct;
    bit      hold_req;

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // append one result to the queue of results still owed by the block
    function automatic void owe_result(input cang_pkg::result_t res);
        due_results = {due_results, res};
    endfunction

    function automatic int extent(input logic [cang_pkg::SIZE_BITS-1:0] s);
        if (s == 0)
            return 1;
        if (s > GRID)
            return GRID;
        return int'(s);
    endfunction

    function automatic bit fold_coord(input int c, input int n, output int r);
        int v;
        v = c;
        if (cur_mode == cang_pkg::MODE_PERIODIC)
        begin
            if (v < 0)
                v = v + n;
            else if (v >= n)
                v = v - n;
        end
        else if (cur_mode == cang_pkg::MODE_REFLECT)
        begin
            if (v < 0)
                v = -v - 1;
            else if (v >= n)
                v = 2 * n - v - 1;
        end
        r = v;
        return (v >= 0 && v < n);
    endfunction

    // Walks the x, y and z lines around the centre; the held label is pushed once
    // the next one shows up, so the final one can carry last.
    function automatic void gather_neighbours(input cang_pkg::item_t it);
        int      n [3];
        int      ctr [3];
        int      p [3];
        int      rad;
        int      a;
        int      off;
        int      c;
        int      hits;
        bit      have_held;
        cang_pkg::result_t held;
        logic [cang_pkg::LABEL_IN_BITS-1:0] v;
        n[0]   = extent(cur_size_x);
        n[1]   = extent(cur_size_y);
        n[2]   = extent(cur_size_z);
        ctr[0] = int'(it.pos_x);
        ctr[1] = int'(it.pos_y);
        ctr[2] = int'(it.pos_z);
        rad    = (cur_reach > cang_pkg::MAX_REACH) ? cang_pkg::MAX_REACH : int'(cur_reach);
        hits   = 0;
        have_held = 1'b0;
        held   = '0;
        if (ctr[0] < n[0] && ctr[1] < n[1] && ctr[2] < n[2])
        begin
            for (a = 0; a < 3; a++)
            begin
                for (off = -rad; off <= rad; off++)
                begin
                    p = ctr;
                    if (!fold_coord(ctr[a] + off, n[a], c))
                        continue;
                    p[a] = c;
                    v = label_mem[(p[0] * GRID + p[1]) * GRID + p[2]];
                    if (v != 0 && hits < MAX_HITS)
                    begin
                        if (have_held)
                            owe_result(held);
                        held.neighbour_label = v;
                        held.found = 1'b1;
                        held.last  = 1'b0;
                        have_held  = 1'b1;
                        hits++;
                    end
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            owe_result(held);
        end
        else
        begin
            held.neighbour_label = '0;
            held.found = 1'b0;
            held.last  = 1'b1;
            owe_result(held);
        end
    endfunction

    function automatic void apply_item(input cang_pkg::item_t it);
        if (it.kind == cang_pkg::KIND_WRITE)
            label_mem[{it.pos_x, it.pos_y, it.pos_z}] = it.label_in;
        else
            gather_neighbours(it);
    endfunction

    function automatic void apply_register(input logic [cang_pkg::REG_IDX_BITS-1:0] idx,
                                           input logic [cang_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            cang_pkg::REG_BOUNDARY_MODE: cur_mode   = data[cang_pkg::MODE_BITS-1:0];
            cang_pkg::REG_REACH:         cur_reach  = data[cang_pkg::REACH_BITS-1:0];
            cang_pkg::REG_SIZE_X:        cur_size_x = data[cang_pkg::SIZE_BITS-1:0];
            cang_pkg::REG_SIZE_Y:        cur_size_y = data[cang_pkg::SIZE_BITS-1:0];
            cang_pkg::REG_SIZE_Z:        cur_size_z = data[cang_pkg::SIZE_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic cang_pkg::item_t make_item(input logic kind, input int x, input int y,
                                                  input int z, input logic [15:0] label);
        cang_pkg::item_t it;
        it.kind     = kind;
        it.pos_x    = cang_pkg::POS_BITS'(x);
        it.pos_y    = cang_pkg::POS_BITS'(y);
        it.pos_z    = cang_pkg::POS_BITS'(z);
        it.label_in = label;
        return it;
    endfunction

    function automatic step_row_t put(input int x, input int y, input int z,
                                      input logic [15:0] label);
        step_row_t row;
        row    = '0;
        row.it = make_item(cang_pkg::KIND_WRITE, x, y, z, label);
        return row;
    endfunction

    function automatic step_row_t ask(input int x, input int y, input int z);
        step_row_t row;
        row    = '0;
        row.it = make_item(cang_pkg::KIND_QUERY, x, y, z, 16'h0000);
        return row;
    endfunction

    // query whose single result is known up front
    function automatic step_row_t ask_t(input int x, input int y, input int z,
                                        input logic [15:0] label, input logic hit);
        step_row_t row;
        row       = ask(x, y, z);
        row.typed = 1'b1;
        row.want  = '{neighbour_label: label, found: hit, last: 1'b1};
        return row;
    endfunction

    function automatic step_row_t setr(input logic [cang_pkg::REG_IDX_BITS-1:0] idx,
                                       input logic [cang_pkg::CFG_DATA_BITS-1:0] data);
        step_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cw     = '{reg_index: idx, wdata: data};
        return row;
    endfunction

    task automatic send_item(input cang_pkg::item_t it, input logic typed,
                             input cang_pkg::result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            items_if.valid = 1'b0;
            @(negedge clk);
        end
        items_if.valid   = 1'b1;
        items_if.payload = it;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        if (typed)
            owe_result(want);
        else
            apply_item(it);
    endtask

    // block is idle once every result is in and the last write has settled
    task automatic wait_drained();
        @(negedge clk);
        items_if.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [cang_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [cang_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_if.valid   = 1'b1;
        cfg_if.payload = '{reg_index: idx, wdata: data};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic logic [cang_pkg::SIZE_BITS-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd32;
            3:       return cang_pkg::SIZE_BITS'($urandom_range(33, 63));
            default: return cang_pkg::SIZE_BITS'($urandom_range(2, 31));
        endcase
    endfunction

    task automatic shuffle_config();
        logic [1:0] upper;
        upper = 2'($urandom);
        cfg_write(cang_pkg::REG_BOUNDARY_MODE, {6'($urandom), 2'($urandom_range(0, 3))});
        cfg_write(cang_pkg::REG_REACH, {5'($urandom), 3'($urandom_range(0, 7))});
        cfg_write(cang_pkg::REG_SIZE_X, {upper, pick_size()});
        cfg_write(cang_pkg::REG_SIZE_Y, {~upper, pick_size()});
        cfg_write(cang_pkg::REG_SIZE_Z, {2'($urandom), pick_size()});
        if ($urandom_range(0, 3) == 0)
            cfg_write(cang_pkg::REG_IDX_BITS'($urandom_range(5, 7)), 8'($urandom));
    endtask

    // result sink: random back-pressure plus one long hold on request
    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_if.ready = 1'b0;
                hold_left--;
            end
            else
                res_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        cang_pkg::result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: neighbour_label %h found %b last %b",
                       res_if.payload.neighbour_label, res_if.payload.found,
                       res_if.payload.last);
                fault_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (res_if.payload.neighbour_label !== want.neighbour_label)
                begin
                    $error("neighbour_label: expected %h, got %h",
                           want.neighbour_label, res_if.payload.neighbour_label);
                    fault_count++;
                end
                if (res_if.payload.found !== want.found)
                begin
                    $error("found: expected %b, got %b", want.found, res_if.payload.found);
                    fault_count++;
                end
                if (res_if.payload.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, res_if.payload.last);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        step_row_t plan [0:PLAN_LEN-1];
        int        i;
        int        ph;
        int        sent;
        int        k;
        int        j;
        int        ax;
        int        rad;
        int        cx;
        int        cy;
        int        cz;
        int        pt [3];
        bit        held_once;
        logic [15:0] lab;

        clk              = 1'b0;
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.payload = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.payload   = '0;
        fault_count      = 0;
        src_idle_pct     = 11;
        sink_idle_pct    = 11;
        hold_req         = 1'b0;
        held_once        = 1'b0;
        for (i = 0; i < GRID * GRID * GRID; i++)
            label_mem[i] = '0;
        cur_mode   = cang_pkg::MODE_RESET;
        cur_reach  = cang_pkg::REACH_RESET;
        cur_size_x = cang_pkg::SIZE_RESET;
        cur_size_y = cang_pkg::SIZE_RESET;
        cur_size_z = cang_pkg::SIZE_RESET;

        plan = '{
            ask_t(0, 0, 0, 16'h0000, 1'b0),
            put(1, 0, 0, 16'hFFFF),
            ask_t(0, 0, 0, 16'hFFFF, 1'b1),
            put(31, 31, 31, 16'h0001),
            put(31, 31, 30, 16'h8000),
            ask(31, 31, 31),
            put(1, 0, 0, 16'h0000),
            ask_t(0, 0, 0, 16'h0000, 1'b0),
            put(0, 0, 0, 16'h5555),
            put(0, 0, 1, 16'hAAAA),
            put(31, 0, 0, 16'h0F0F),
            setr(cang_pkg::REG_BOUNDARY_MODE,
                 cang_pkg::CFG_DATA_BITS'(cang_pkg::MODE_PERIODIC)),
            setr(cang_pkg::REG_REACH, 8'd7),
            ask(0, 0, 0),
            setr(cang_pkg::REG_BOUNDARY_MODE,
                 cang_pkg::CFG_DATA_BITS'(cang_pkg::MODE_REFLECT)),
            ask(0, 0, 0),
            ask(31, 31, 31),
            setr(cang_pkg::REG_BOUNDARY_MODE, cang_pkg::CFG_DATA_BITS'(MODE_SPARE)),
            ask(0, 0, 0),
            setr(cang_pkg::REG_SIZE_X, 8'd0),
            setr(cang_pkg::REG_SIZE_Y, 8'd63),
            setr(cang_pkg::REG_SIZE_Z, 8'd1),
            // centre beyond an x extent of one
            ask_t(1, 0, 0, 16'h0000, 1'b0),
            setr(cang_pkg::REG_BOUNDARY_MODE,
                 cang_pkg::CFG_DATA_BITS'(cang_pkg::MODE_REFLECT)),
            ask(0, 0, 0),
            setr(cang_pkg::REG_REACH, 8'd0),
            setr(cang_pkg::REG_SIZE_X, 8'd32),
            setr(cang_pkg::REG_SIZE_Z, 8'd33),
            ask(0, 0, 0),
            put(0, 0, 0, 16'h1234),
            ask(0, 31, 0),
            setr(cang_pkg::REG_REACH, 8'hF9),
            setr(REG_UNUSED, 8'hFF),
            ask(31, 31, 31)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                cfg_write(plan[i].cw.reg_index, plan[i].cw.wdata);
            end
            else
                send_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            // one stretch with no idling on either side
            src_idle_pct  = (ph == 3) ? 0 : 11;
            sink_idle_pct = (ph == 3) ? 0 : 11;
            shuffle_config();
            rad  = (cur_reach > cang_pkg::MAX_REACH) ? cang_pkg::MAX_REACH : int'(cur_reach);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 1 && sent >= 6 && !held_once)
                begin
                    hold_req  = 1'b1;
                    held_once = 1'b1;
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    // a few labels on the centre's lines, then the query
                    if ($urandom_range(0, 9) == 0)
                    begin
                        cx = $urandom_range(0, 31);
                        cy = $urandom_range(0, 31);
                        cz = $urandom_range(0, 31);
                    end
                    else
                    begin
                        cx = $urandom_range(0, extent(cur_size_x) - 1);
                        cy = $urandom_range(0, extent(cur_size_y) - 1);
                        cz = $urandom_range(0, extent(cur_size_z) - 1);
                    end
                    k = $urandom_range(1, 4);
                    for (j = 0; j < k; j++)
                    begin
                        pt[0] = cx;
                        pt[1] = cy;
                        pt[2] = cz;
                        ax = $urandom_range(0, 2);
                        pt[ax] = (pt[ax] + int'($urandom_range(0, 2 * rad)) - rad) & 31;
                        lab = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
                        send_item(make_item(cang_pkg::KIND_WRITE, pt[0], pt[1], pt[2], lab),
                                  1'b0, '0);
                        sent++;
                    end
                    send_item(make_item(cang_pkg::KIND_QUERY, cx, cy, cz, 16'($urandom)),
                              1'b0, '0);
                    sent++;
                end
                else
                begin
                    send_item(make_item(1'($urandom), $urandom_range(0, 31),
                                        $urandom_range(0, 31), $urandom_range(0, 31),
                                        16'($urandom)), 1'b0, '0);
                    sent++;
                end
            end
        end

        @(negedge clk);
        items_if.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== ca_axis_neighbourhood_gather.f =====
hw/rtl/cang_pkg.sv
hw/rtl/cang_if.sv
hw/rtl/cang_cell_mem.sv
hw/rtl/cang_query_engine.sv
hw/rtl/ca_axis_neighbourhood_gather.sv
sim/testbench.sv
